// File: rtl/trackpad_gesture_to_mouse_assert.svh
// Assertion macros for the RTL of the trackpad gesture block.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef TRACKPAD_GESTURE_TO_MOUSE_ASSERT_SVH
`define TRACKPAD_GESTURE_TO_MOUSE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequence holds in the same cycle as the condition.
`define TGM_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequence holds in the cycle after the condition.
`define TGM_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define TGM_ASSERT_SAME(label, clk, rst, cond, cons)
`define TGM_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// File: rtl/tgm_pkg.sv
package tgm_pkg;

   // Item kinds on the request channel.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_WINDOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_WINDOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_TRAVEL  = 2'd2;

   // Configuration reset values.
   localparam logic [15:0] TAP_WINDOW_RST  = 16'd300;
   localparam logic [15:0] HOLD_WINDOW_RST = 16'd200;
   localparam logic [15:0] TAP_TRAVEL_RST  = 16'd15;

   // Finger count clamp and default scroll divisor.
   localparam logic [2:0] MAX_FINGERS     = 3'd5;
   localparam int         SCROLL_DIV_DEF  = 4;

   // Report button bits.
   localparam logic [2:0] BTN_LEFT   = 3'h1;
   localparam logic [2:0] BTN_RIGHT  = 3'h2;
   localparam logic [2:0] BTN_MIDDLE = 3'h4;

   // Gesture states.
   typedef enum logic [2:0] {
      G_NONE         = 3'd0,
      G_POSSIBLE_TAP = 3'd1,
      G_HOLD         = 3'd2,
      G_DOUBLE_TAP   = 3'd3,
      G_RIGHT_CLICK  = 3'd4
   } gesture_type;

   // One registered request item.
   typedef struct packed {
      logic        op;
      logic [2:0]  touch_count;
      logic [15:0] first_x;
      logic [15:0] first_y;
      logic        first_touching;
      logic        button_left;
      logic        button_right;
      logic        button_middle;
   } req_item_type;

   // Clamp a signed delta to the report range of plus or minus 127.
   function automatic logic signed [7:0] sat8(input logic signed [17:0] v);
      logic signed [7:0] r;
      if (v > 18'sd127) begin
         r = 8'sd127;
      end else if (v < -18'sd127) begin
         r = -8'sd127;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/tgm_req_if.sv
interface tgm_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [2:0]  touch_count;
   logic [15:0] first_x;
   logic [15:0] first_y;
   logic        first_touching;
   logic        button_left;
   logic        button_right;
   logic        button_middle;

   modport source (
      output valid, op, touch_count, first_x, first_y, first_touching,
             button_left, button_right, button_middle,
      input  ready
   );

   modport sink (
      input  valid, op, touch_count, first_x, first_y, first_touching,
             button_left, button_right, button_middle,
      output ready
   );
endinterface

// File: rtl/tgm_rsp_if.sv
interface tgm_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        buttons;
   logic signed [7:0] move_x;
   logic signed [7:0] move_y;
   logic signed [7:0] scroll_h;
   logic signed [7:0] scroll_v;

   modport source (
      output valid, buttons, move_x, move_y, scroll_h, scroll_v,
      input  ready
   );

   modport sink (
      input  valid, buttons, move_x, move_y, scroll_h, scroll_v,
      output ready
   );
endinterface

// File: rtl/trackpad_gesture_to_mouse.sv
// Trackpad gesture recognizer producing mouse reports.
// The request channel carries two kinds of transaction: a tick advances the
// millisecond time base and produces nothing; a frame carries the finger
// count, the first contact position and the physical buttons, and produces
// exactly one report transaction on the response channel (buttons, pointer
// deltas, scroll deltas, each delta saturated to plus or minus 127).
// The user must write registers on the csr port only while the block is idle;
// the block does not enforce this. A transaction is taken into an input
// register; when it moves on, the gesture logic runs once on it and loads the
// report register, from which the report is offered on the response channel.
// One transaction per cycle is sustained while the receiver takes reports; the
// combinational state update through the gesture compares and the scroll
// reciprocal multiply sets that figure. When the receiver stalls, the report holds
// and one more transaction waits in the input register; ticks keep flowing while a
// report waits, until a frame reaches the input register.
// Synchronous reset clears the time base, the gesture state and both
// channel registers, and reloads the register defaults.
`include "trackpad_gesture_to_mouse_assert.svh"

module trackpad_gesture_to_mouse
   import tgm_pkg::*;
#(
   parameter int SCROLL_DIV = SCROLL_DIV_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   tgm_req_if.sink                req_chan,
   tgm_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);

   // Channel registers.
   req_item_type      in_item_ff;
   logic              in_valid_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_buttons_ff, rsp_buttons_in;
   logic signed [7:0] rsp_move_x_ff, rsp_move_x_in;
   logic signed [7:0] rsp_move_y_ff, rsp_move_y_in;
   logic signed [7:0] rsp_scroll_h_ff, rsp_scroll_h_in;
   logic signed [7:0] rsp_scroll_v_ff, rsp_scroll_v_in;

   // Configuration registers.
   logic [15:0] tap_window_ff;
   logic [15:0] hold_window_ff;
   logic [15:0] tap_travel_ff;

   // Gesture state.
   logic [31:0]       now_ff, now_in;
   gesture_type       gesture_ff, gesture_in;
   logic [31:0]       tap_stamp_ff, tap_stamp_in;
   logic [31:0]       contact_stamp_ff, contact_stamp_in;
   logic [15:0]       start_x_ff, start_x_in;
   logic [15:0]       start_y_ff, start_y_in;
   logic [2:0]        peak_ff, peak_in;
   logic [2:0]        prev_touches_ff, prev_touches_in;
   logic [15:0]       prev_x_ff, prev_x_in;
   logic [15:0]       prev_y_ff, prev_y_in;
   logic              prev_touching_ff, prev_touching_in;
   logic signed [7:0] carry_h_ff, carry_h_in;
   logic signed [7:0] carry_v_ff, carry_v_in;

   // Handshake and datapath signals.
   logic              advance;
   logic              fire_tick;
   logic              fire_frame;
   logic              req_take;
   logic signed [7:0] scroll_h_q, scroll_h_r;
   logic signed [7:0] scroll_v_q, scroll_v_r;

   // The input register moves on when its item is a tick or the report slot frees.
   assign advance    = in_valid_ff &&
                       ((in_item_ff.op == OP_TICK) || !rsp_valid_ff || rsp_chan.ready);
   assign fire_tick  = advance && (in_item_ff.op == OP_TICK);
   assign fire_frame = advance && (in_item_ff.op == OP_FRAME);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take   = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.op             <= req_chan.op;
         in_item_ff.touch_count    <= req_chan.touch_count;
         in_item_ff.first_x        <= req_chan.first_x;
         in_item_ff.first_y        <= req_chan.first_y;
         in_item_ff.first_touching <= req_chan.first_touching;
         in_item_ff.button_left    <= req_chan.button_left;
         in_item_ff.button_right   <= req_chan.button_right;
         in_item_ff.button_middle  <= req_chan.button_middle;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_window_ff  <= TAP_WINDOW_RST;
         hold_window_ff <= HOLD_WINDOW_RST;
         tap_travel_ff  <= TAP_TRAVEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_WINDOW:  tap_window_ff  <= csr_wdata;
            CSR_HOLD_WINDOW: hold_window_ff <= csr_wdata;
            CSR_TAP_TRAVEL:  tap_travel_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Scroll dividers, one per axis.
   tgm_scroll_div #(.SCROLL_DIV(SCROLL_DIV)) u_div_h (
      .cur_pos  (in_item_ff.first_x),
      .prev_pos (prev_x_ff),
      .carry_in (carry_h_ff),
      .quot_sat (scroll_h_q),
      .rem_out  (scroll_h_r)
   );

   tgm_scroll_div #(.SCROLL_DIV(SCROLL_DIV)) u_div_v (
      .cur_pos  (in_item_ff.first_y),
      .prev_pos (prev_y_ff),
      .carry_in (carry_v_ff),
      .quot_sat (scroll_v_q),
      .rem_out  (scroll_v_r)
   );

   // Gesture logic for one item.
   always_comb begin
      logic [2:0]         touches;
      gesture_type        aged;
      logic [31:0]        since_tap;
      logic [31:0]        duration;
      logic [15:0]        dx;
      logic [15:0]        dy;
      logic               moving;
      logic signed [17:0] dmx;
      logic signed [17:0] dmy;

      now_in           = now_ff;
      gesture_in       = gesture_ff;
      tap_stamp_in     = tap_stamp_ff;
      contact_stamp_in = contact_stamp_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      peak_in          = peak_ff;
      prev_touches_in  = prev_touches_ff;
      prev_x_in        = prev_x_ff;
      prev_y_in        = prev_y_ff;
      prev_touching_in = prev_touching_ff;
      carry_h_in       = carry_h_ff;
      carry_v_in       = carry_v_ff;
      rsp_buttons_in   = '0;
      rsp_move_x_in    = '0;
      rsp_move_y_in    = '0;
      rsp_scroll_h_in  = '0;
      rsp_scroll_v_in  = '0;

      touches   = (in_item_ff.touch_count > MAX_FINGERS) ? MAX_FINGERS
                                                         : in_item_ff.touch_count;
      since_tap = now_ff - tap_stamp_ff;
      duration  = now_ff - contact_stamp_ff;
      dx        = (in_item_ff.first_x >= start_x_ff) ? in_item_ff.first_x - start_x_ff
                                                     : start_x_ff - in_item_ff.first_x;
      dy        = (in_item_ff.first_y >= start_y_ff) ? in_item_ff.first_y - start_y_ff
                                                     : start_y_ff - in_item_ff.first_y;
      moving    = in_item_ff.first_touching && prev_touching_ff;
      dmx       = $signed({2'b00, in_item_ff.first_x}) - $signed({2'b00, prev_x_ff});
      dmy       = $signed({2'b00, in_item_ff.first_y}) - $signed({2'b00, prev_y_ff});

      // Age the gesture at the start of every frame.
      unique case (gesture_ff)
         G_POSSIBLE_TAP: aged = (since_tap >= {16'd0, hold_window_ff}) ? G_NONE
                                                                        : G_POSSIBLE_TAP;
         G_DOUBLE_TAP:   aged = G_POSSIBLE_TAP;
         G_RIGHT_CLICK:  aged = G_NONE;
         default:        aged = gesture_ff;
      endcase

      if (fire_tick) begin
         now_in = now_ff + 32'd1;
      end

      if (fire_frame) begin
         gesture_in = aged;

         if (prev_touches_ff == 3'd0) begin
            // Contact begins: remember where and when.
            peak_in = 3'd0;
            if (touches != 3'd0) begin
               contact_stamp_in = now_ff;
               start_x_in       = in_item_ff.first_x;
               start_y_in       = in_item_ff.first_y;
               if (aged == G_POSSIBLE_TAP) begin
                  gesture_in   = G_HOLD;
                  tap_stamp_in = now_ff;
               end
            end
         end else begin
            if (touches > peak_ff) begin
               peak_in = touches;
            end
            if (touches == 3'd0) begin
               // Lift: classify the contact that just ended.
               if (aged == G_HOLD) begin
                  gesture_in = (since_tap < {16'd0, hold_window_ff}) ? G_DOUBLE_TAP : G_NONE;
               end else if (duration < {16'd0, tap_window_ff}) begin
                  if (peak_ff == 3'd2) begin
                     gesture_in   = G_RIGHT_CLICK;
                     tap_stamp_in = now_ff;
                  end else if (dx < tap_travel_ff && dy < tap_travel_ff) begin
                     gesture_in   = G_POSSIBLE_TAP;
                     tap_stamp_in = now_ff;
                  end
               end
            end else if (touches == 3'd1) begin
               // One finger moves the pointer.
               if (moving) begin
                  rsp_move_x_in = sat8(dmx);
                  rsp_move_y_in = sat8(dmy);
               end
            end else if (touches == 3'd2) begin
               // Two fingers scroll, carrying the division remainder.
               if (moving) begin
                  rsp_scroll_h_in = scroll_h_q;
                  rsp_scroll_v_in = scroll_v_q;
                  carry_h_in      = scroll_h_r;
                  carry_v_in      = scroll_v_r;
               end
            end
         end

         // Report buttons from the physical switches and the gesture.
         if (in_item_ff.button_left || gesture_in == G_HOLD ||
             gesture_in == G_POSSIBLE_TAP) begin
            rsp_buttons_in = rsp_buttons_in | BTN_LEFT;
         end
         if (in_item_ff.button_right || gesture_in == G_RIGHT_CLICK) begin
            rsp_buttons_in = rsp_buttons_in | BTN_RIGHT;
         end
         if (in_item_ff.button_middle) begin
            rsp_buttons_in = rsp_buttons_in | BTN_MIDDLE;
         end

         prev_touches_in  = touches;
         prev_x_in        = in_item_ff.first_x;
         prev_y_in        = in_item_ff.first_y;
         prev_touching_in = in_item_ff.first_touching;
      end
   end

   // Gesture state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff           <= '0;
         gesture_ff       <= G_NONE;
         tap_stamp_ff     <= '0;
         contact_stamp_ff <= '0;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         peak_ff          <= '0;
         prev_touches_ff  <= '0;
         prev_x_ff        <= '0;
         prev_y_ff        <= '0;
         prev_touching_ff <= 1'b0;
         carry_h_ff       <= '0;
         carry_v_ff       <= '0;
      end else begin
         now_ff           <= now_in;
         gesture_ff       <= gesture_in;
         tap_stamp_ff     <= tap_stamp_in;
         contact_stamp_ff <= contact_stamp_in;
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         peak_ff          <= peak_in;
         prev_touches_ff  <= prev_touches_in;
         prev_x_ff        <= prev_x_in;
         prev_y_ff        <= prev_y_in;
         prev_touching_ff <= prev_touching_in;
         carry_h_ff       <= carry_h_in;
         carry_v_ff       <= carry_v_in;
      end
   end

   // Report register: loads on a frame, clears when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire_frame) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_frame) begin
         rsp_buttons_ff  <= rsp_buttons_in;
         rsp_move_x_ff   <= rsp_move_x_in;
         rsp_move_y_ff   <= rsp_move_y_in;
         rsp_scroll_h_ff <= rsp_scroll_h_in;
         rsp_scroll_v_ff <= rsp_scroll_v_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.buttons  = rsp_buttons_ff;
   assign rsp_chan.move_x   = rsp_move_x_ff;
   assign rsp_chan.move_y   = rsp_move_y_ff;
   assign rsp_chan.scroll_h = rsp_scroll_h_ff;
   assign rsp_chan.scroll_v = rsp_scroll_v_ff;

   // A report only appears after a frame was processed.
   `TGM_ASSERT_SAME(a_rsp_from_frame, clock, reset, $rose(rsp_valid_ff), $past(fire_frame))
   // Ticks advance the time base by one and leave the gesture alone.
   `TGM_ASSERT_NEXT(a_tick_count, clock, reset, fire_tick, now_ff == $past(now_ff) + 32'd1)
   `TGM_ASSERT_NEXT(a_tick_gesture, clock, reset, fire_tick, $stable(gesture_ff))
   // A hold or possible tap always reports the left button.
   `TGM_ASSERT_NEXT(a_hold_left, clock, reset,
                    fire_frame && (gesture_in == G_HOLD || gesture_in == G_POSSIBLE_TAP),
                    rsp_buttons_ff[0])

endmodule

// File: rtl/tgm_scroll_div.sv
// Scroll axis divider: adds the carried remainder to the position delta and
// divides by a constant, truncating toward zero. The quotient is saturated
// for the report and the remainder, with the sign of the dividend, is the
// next carry. The division is a multiplication by a rounded-up reciprocal,
// exact for every dividend magnitude below 2**17.
module tgm_scroll_div
   import tgm_pkg::*;
#(
   parameter int SCROLL_DIV = SCROLL_DIV_DEF
) (
   input  logic [15:0]       cur_pos,
   input  logic [15:0]       prev_pos,
   input  logic signed [7:0] carry_in,
   output logic signed [7:0] quot_sat,
   output logic signed [7:0] rem_out
);

   localparam int MAG_W    = 17;
   localparam int DIV_BITS = $clog2(SCROLL_DIV);
   localparam int SHIFT    = MAG_W + DIV_BITS;
   localparam int RECIP_W  = 19;
   localparam int PROD_W   = SHIFT + MAG_W;
   localparam longint RECIP = ((longint'(1) << SHIFT) + SCROLL_DIV - 1) / SCROLL_DIV;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

   logic signed [17:0] dividend;
   logic               negative;
   logic [MAG_W-1:0]   magnitude;
   logic [PROD_W-1:0]  product;
   logic [MAG_W-1:0]   quot_mag;
   logic [MAG_W-1:0]   rem_mag;
   logic signed [17:0] quot_signed;
   logic signed [7:0]  rem_signed;

   // Signed dividend and its magnitude.
   assign dividend  = $signed({2'b00, cur_pos}) - $signed({2'b00, prev_pos})
                      + $signed({{10{carry_in[7]}}, carry_in});
   assign negative  = dividend[17];
   assign magnitude = negative ? MAG_W'(-dividend) : dividend[MAG_W-1:0];

   // Quotient by reciprocal multiplication, remainder by constant multiply-back.
   assign product  = PROD_W'(magnitude) * PROD_W'(RECIP_C);
   assign quot_mag = product[SHIFT +: MAG_W];
   assign rem_mag  = magnitude - MAG_W'(quot_mag * SCROLL_DIV);

   // Restore the sign of the dividend on both results.
   always_comb begin
      if (negative) begin
         quot_signed = -$signed({1'b0, quot_mag});
         rem_signed  = -$signed({1'b0, rem_mag[6:0]});
      end else begin
         quot_signed = $signed({1'b0, quot_mag});
         rem_signed  = $signed({1'b0, rem_mag[6:0]});
      end
   end

   assign quot_sat = sat8(quot_signed);
   assign rem_out  = rem_signed;

endmodule
